/* rtl/scc_demap_pkg.sv */
// ----------------------------------------------------------------------------
// Soft codeword correlation demapper package
// Fixed widths and counts shared by the demapper RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_demap_pkg;

  localparam int NUM_PAIRS     = 8;
  localparam int PAIR_W        = 64;
  localparam int CFG_IDX_W     = 4;
  localparam int PAIR_SEL_W    = 3;
  localparam int MAX_CODEWORDS = 16;
  localparam int CW_IDX_W      = 4;
  localparam int CHIP_IDX_W    = 5;
  localparam int SAMPLE_PORT_W = 12;
  localparam int SAMPLE_MAX_W  = 16;
  localparam int BIT_SEL_W     = 2;
  localparam int NUM_GROUPS    = 4;

  typedef logic [PAIR_W-1:0]   pair_t;
  typedef logic [CW_IDX_W-1:0] cw_idx_t;

endpackage

`default_nettype wire

/* rtl/soft_codeword_correlation_demapper_top.sv */
// ----------------------------------------------------------------------------
// Soft codeword correlation demapper
// Correlates soft chips against up to 16 bipolar codewords and emits the
// index of the best match MSB first, one bit per transfer.
// ----------------------------------------------------------------------------
// Pipeline: the last chip of a word is taken into the snapshot register, then
//   the 16-to-4 compare tree register, then the symbol register (first bit).
// Throughput: one chip in and one symbol bit out per cycle, when not stalled.
//   in_stall rises only when the snapshot register is full and blocked.
// Reset: accumulators, chip counter, codeword registers and all valids clear.
`default_nettype none

module soft_codeword_correlation_demapper_top #(
  parameter int NUM_CODEWORDS  = 16,
  parameter int CHIPS_PER_WORD = 32,
  parameter int BITS_PER_WORD  = 4,
  parameter int SAMPLE_WIDTH   = 12
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          cfg_we,
  input  wire logic [scc_demap_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [scc_demap_pkg::PAIR_W-1:0]              cfg_data,
  input  wire logic                                          in_valid,
  output logic                                               in_stall,
  input  wire logic signed [scc_demap_pkg::SAMPLE_PORT_W-1:0] in_soft_chip,
  output logic                                               out_valid,
  input  wire logic                                          out_stall,
  output logic                                               out_symbol_bit,
  output logic                                               out_last_bit
);

  localparam int POS_W = $clog2(CHIPS_PER_WORD);
  localparam int ACC_W = SAMPLE_WIDTH + $clog2(CHIPS_PER_WORD) + 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(CHIPS_PER_WORD - 1);
  localparam logic [scc_demap_pkg::BIT_SEL_W-1:0] LAST_SEL =
    scc_demap_pkg::BIT_SEL_W'(BITS_PER_WORD - 1);

  typedef struct packed {
    logic                   vld;
    scc_demap_pkg::cw_idx_t idx;
    logic signed [ACC_W-1:0] sum;
  } cand_t;

  function automatic cand_t pick(cand_t a, cand_t b);
    pick = (b.vld && (!a.vld || (b.sum > a.sum))) ? b : a;
  endfunction

  scc_demap_pkg::pair_t cw_pair_r [scc_demap_pkg::NUM_PAIRS];

  logic [POS_W-1:0]          pos_r;
  logic signed [ACC_W-1:0]   acc_r  [NUM_CODEWORDS];
  logic signed [ACC_W-1:0]   snap_r [NUM_CODEWORDS];
  logic                      snap_vld_r;
  cand_t                     t1_r [scc_demap_pkg::NUM_GROUPS];
  logic                      t1_vld_r;
  scc_demap_pkg::cw_idx_t    sym_idx_r;
  logic                      sym_vld_r;
  logic [scc_demap_pkg::BIT_SEL_W-1:0] bit_cnt_r;

  logic in_xfer;
  logic out_xfer;
  logic last_chip;
  logic sym_free;
  logic t1_ok;
  logic [scc_demap_pkg::CHIP_IDX_W-1:0] pos5;
  logic signed [scc_demap_pkg::SAMPLE_MAX_W-1:0] chip_ext;
  logic signed [SAMPLE_WIDTH-1:0]  samp;
  logic signed [ACC_W-1:0]         samp_ext;
  logic signed [ACC_W-1:0]         sum_nxt [NUM_CODEWORDS];
  cand_t                           leaf [scc_demap_pkg::MAX_CODEWORDS];
  cand_t                           grp_nxt [scc_demap_pkg::NUM_GROUPS];
  cand_t                           best;
  logic [scc_demap_pkg::BIT_SEL_W-1:0] bit_sel;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < scc_demap_pkg::NUM_PAIRS; i++) begin
        cw_pair_r[i] <= '0;
      end
    end else if (cfg_we &&
                 (cfg_index < scc_demap_pkg::CFG_IDX_W'(scc_demap_pkg::NUM_PAIRS))) begin
      cw_pair_r[cfg_index[scc_demap_pkg::PAIR_SEL_W-1:0]] <= cfg_data;
    end
  end

  // Handshake
  assign sym_free  = !sym_vld_r || (out_xfer && (bit_cnt_r == LAST_SEL));
  assign t1_ok     = !t1_vld_r || sym_free;
  assign in_stall  = snap_vld_r && !t1_ok;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign last_chip = (pos_r == LAST_POS);

  // Sample
  assign chip_ext = scc_demap_pkg::SAMPLE_MAX_W'(in_soft_chip);
  assign samp     = chip_ext[SAMPLE_WIDTH-1:0];
  assign samp_ext = ACC_W'(samp);
  assign pos5     = scc_demap_pkg::CHIP_IDX_W'(pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_xfer) begin
      pos_r <= last_chip ? '0 : pos_r + POS_W'(1);
    end
  end

  // Correlation lanes
  for (genvar c = 0; c < NUM_CODEWORDS; c++) begin : g_lane
    localparam logic HALF = 1'(c % 2);
    localparam int   PAIR = c / 2;

    assign sum_nxt[c] = cw_pair_r[PAIR][{HALF, pos5}] ? acc_r[c] - samp_ext
                                                      : acc_r[c] + samp_ext;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        acc_r[c] <= '0;
      end else if (in_xfer) begin
        acc_r[c] <= last_chip ? '0 : sum_nxt[c];
      end
    end

    always_ff @(posedge clk) begin
      if (in_xfer && last_chip) begin
        snap_r[c] <= sum_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_vld_r <= 1'b0;
    end else if (in_xfer && last_chip) begin
      snap_vld_r <= 1'b1;
    end else if (t1_ok) begin
      snap_vld_r <= 1'b0;
    end
  end

  // Compare tree, first half
  for (genvar c = 0; c < scc_demap_pkg::MAX_CODEWORDS; c++) begin : g_leaf
    if (c < NUM_CODEWORDS) begin : g_used
      assign leaf[c] = '{vld: 1'b1, idx: scc_demap_pkg::CW_IDX_W'(c), sum: snap_r[c]};
    end else begin : g_unused
      assign leaf[c] = '{vld: 1'b0, idx: scc_demap_pkg::CW_IDX_W'(c), sum: '0};
    end
  end

  for (genvar g = 0; g < scc_demap_pkg::NUM_GROUPS; g++) begin : g_grp
    assign grp_nxt[g] = pick(pick(leaf[4*g],   leaf[4*g+1]),
                             pick(leaf[4*g+2], leaf[4*g+3]));
  end

  always_ff @(posedge clk) begin
    if (t1_ok && snap_vld_r) begin
      t1_r <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
    end else if (t1_ok) begin
      t1_vld_r <= snap_vld_r;
    end
  end

  // Compare tree, second half, into the symbol register
  assign best = pick(pick(t1_r[0], t1_r[1]), pick(t1_r[2], t1_r[3]));

  always_ff @(posedge clk) begin
    if (sym_free && t1_vld_r) begin
      sym_idx_r <= best.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_vld_r <= 1'b0;
      bit_cnt_r <= '0;
    end else begin
      if (sym_free) begin
        sym_vld_r <= t1_vld_r;
      end
      if (out_xfer) begin
        bit_cnt_r <= (bit_cnt_r == LAST_SEL) ? '0
                                             : bit_cnt_r + scc_demap_pkg::BIT_SEL_W'(1);
      end
    end
  end

  // Serialize MSB first
  assign bit_sel        = LAST_SEL - bit_cnt_r;
  assign out_valid      = sym_vld_r;
  assign out_symbol_bit = sym_idx_r[bit_sel];
  assign out_last_bit   = (bit_cnt_r == LAST_SEL);

  // Checks
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("chip counter beyond word length");

  a_snap_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && last_chip |=> snap_vld_r)
    else $error("last chip of word did not load snapshot");

  a_symbol_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_last_bit |=> out_valid && (bit_cnt_r == $past(bit_cnt_r) + 2'd1))
    else $error("symbol dropped before last bit");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !sym_vld_r |-> (bit_cnt_r == '0))
    else $error("bit counter not at start while no symbol held");

endmodule

`default_nettype wire

/* tb/soft_codeword_correlation_demapper_top_tb.sv */
// ----------------------------------------------------------------------------
// Soft codeword correlation demapper testbench
// Streams soft chips into the demapper under random source gaps and sink
// stalls. A local correlator tracks the codebook registers and per-codeword
// sums, and queues the symbol bits each completed word must produce. Every
// output transfer is checked against that queue. Codebook changes are made
// only with the block drained: reset state, register extremes, ignored
// register indexes, ties, mid-word changes and random traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_codeword_correlation_demapper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHIPS        = 32;
  localparam int SYMBOL_BITS  = 4;
  localparam int SAMPLE_MIN   = -2048;
  localparam int SAMPLE_MAX   = 2047;
  localparam int GAP_MAX      = 18;
  localparam int DRAIN_CYCLES = 8;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_WORDS = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TIE_CW       = 7;
  localparam int IDX_W        = scc_demap_pkg::CFG_IDX_W;
  localparam int CHIP_W       = scc_demap_pkg::SAMPLE_PORT_W;

  typedef struct packed {
    logic symbol_bit;
    logic last_bit;
  } symbol_bit_t;

  logic                                    clk = 1'b0;
  logic                                    rst_n;
  logic                                    cfg_we;
  logic [IDX_W-1:0]                        cfg_index;
  logic [scc_demap_pkg::PAIR_W-1:0]        cfg_data;
  logic                                    in_valid;
  logic                                    in_stall;
  logic signed [CHIP_W-1:0]                in_soft_chip;
  logic                                    out_valid;
  logic                                    out_stall;
  logic                                    out_symbol_bit;
  logic                                    out_last_bit;

  scc_demap_pkg::pair_t                    codeword_regs [scc_demap_pkg::NUM_PAIRS];
  int                                      corr_sums [scc_demap_pkg::MAX_CODEWORDS];
  int                                      chip_pos;
  symbol_bit_t                             expected_bits [$];
  logic signed [CHIP_W-1:0]                word_chips [CHIPS];

  int src_gap_max;
  int sink_gap_max;
  int error_count;
  int chips_sent;
  int symbols_decoded;
  int config_writes;
  int cycle_count;

  soft_codeword_correlation_demapper_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_soft_chip   (in_soft_chip),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol_bit (out_symbol_bit),
    .out_last_bit   (out_last_bit)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("soft_codeword_correlation_demapper_top_tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(string field, int want, int got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    symbol_bit_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bits.size() == 0) begin
        report_mismatch("unexpected transfer (symbol_bit)", -1, int'(out_symbol_bit));
      end else begin
        want = expected_bits.pop_front();
        if (out_symbol_bit !== want.symbol_bit)
          report_mismatch("symbol_bit", int'(want.symbol_bit), int'(out_symbol_bit));
        if (out_last_bit !== want.last_bit)
          report_mismatch("last_bit", int'(want.last_bit), int'(out_last_bit));
      end
    end
  end

  initial begin : sink_stall
    int gap;
    out_stall = 1'b0;
    forever begin
      gap = $urandom_range(0, sink_gap_max);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
    end
  end

  // Accumulate one chip; on the last chip of a word queue the winning index.
  task automatic correlate_chip(logic signed [CHIP_W-1:0] chip);
    int s;
    int best;
    symbol_bit_t b;
    s = int'(chip);
    for (int c = 0; c < scc_demap_pkg::MAX_CODEWORDS; c++) begin
      if (codeword_regs[c >> 1][(c & 1) * 32 + chip_pos])
        corr_sums[c] -= s;
      else
        corr_sums[c] += s;
    end
    if (chip_pos + 1 < CHIPS) begin
      chip_pos++;
      return;
    end
    best = 0;
    for (int c = 1; c < scc_demap_pkg::MAX_CODEWORDS; c++)
      if (corr_sums[c] > corr_sums[best]) best = c;
    for (int bi = SYMBOL_BITS - 1; bi >= 0; bi--) begin
      b.symbol_bit = 1'((best >> bi) & 1);
      b.last_bit   = (bi == 0);
      expected_bits.push_back(b);
    end
    for (int c = 0; c < scc_demap_pkg::MAX_CODEWORDS; c++) corr_sums[c] = 0;
    chip_pos = 0;
    symbols_decoded++;
  endtask

  task automatic send_chip(logic signed [CHIP_W-1:0] chip);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_soft_chip <= chip;
    do @(posedge clk); while (in_stall);
    correlate_chip(chip);
    chips_sent++;
  endtask

  task automatic send_word;
    for (int i = 0; i < CHIPS; i++) send_chip(word_chips[i]);
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(logic [IDX_W-1:0] idx, scc_demap_pkg::pair_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx < scc_demap_pkg::NUM_PAIRS)
      codeword_regs[idx[scc_demap_pkg::PAIR_SEL_W-1:0]] = data;
    config_writes++;
  endtask

  task automatic randomize_codebook;
    scc_demap_pkg::pair_t val;
    logic [31:0]          half;
    for (int p = 0; p < scc_demap_pkg::NUM_PAIRS; p++) begin
      half = $urandom;
      case ($urandom_range(0, 5))
        0:       val = '0;
        1:       val = '1;
        2:       val = {half, half};
        default: val = {$urandom, $urandom};
      endcase
      apply_config(IDX_W'(p), val);
    end
    if ($urandom_range(0, 1))
      apply_config(IDX_W'(scc_demap_pkg::NUM_PAIRS +
                          $urandom_range(0, scc_demap_pkg::NUM_PAIRS - 1)),
                   {$urandom, $urandom});
  endtask

  task automatic build_codeword_word(int k, int amp, int noise);
    logic [31:0] signs;
    int          v;
    signs = codeword_regs[k >> 1][(k & 1) * 32 +: 32];
    for (int i = 0; i < CHIPS; i++) begin
      v = signs[i] ? -amp : amp;
      v += int'($urandom_range(0, 2 * noise)) - noise;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      word_chips[i] = v[CHIP_W-1:0];
    end
  endtask

  task automatic test_reset_state;
    for (int i = 0; i < CHIPS; i++) begin
      case (i % 4)
        0:       word_chips[i] = CHIP_W'(SAMPLE_MAX);
        1:       word_chips[i] = CHIP_W'(SAMPLE_MIN);
        2:       word_chips[i] = '0;
        default: word_chips[i] = '1;
      endcase
    end
    send_word();
    drain_results();
  endtask

  task automatic test_register_extremes;
    for (int p = 0; p < scc_demap_pkg::NUM_PAIRS; p++)
      apply_config(IDX_W'(p), (p == scc_demap_pkg::NUM_PAIRS - 1) ? '1 : '0);
    for (int i = 0; i < CHIPS; i++) word_chips[i] = CHIP_W'(SAMPLE_MIN);
    send_word();
    drain_results();
    apply_config('0, '1);
    apply_config(IDX_W'(scc_demap_pkg::NUM_PAIRS - 1), '0);
    for (int i = 0; i < CHIPS; i++) word_chips[i] = CHIP_W'(SAMPLE_MAX);
    send_word();
    drain_results();
  endtask

  task automatic test_ignored_index;
    for (int idx = scc_demap_pkg::NUM_PAIRS; idx < 2 ** IDX_W; idx++)
      apply_config(IDX_W'(idx), '1);
    for (int i = 0; i < CHIPS; i++) word_chips[i] = CHIP_W'(SAMPLE_MAX);
    send_word();
    drain_results();
  endtask

  task automatic test_codeword_match;
    logic [31:0] half;
    for (int p = 0; p < scc_demap_pkg::NUM_PAIRS; p++)
      apply_config(IDX_W'(p), {$urandom, $urandom});
    build_codeword_word(scc_demap_pkg::MAX_CODEWORDS - 1, SAMPLE_MAX, 0);
    send_word();
    drain_results();
    // identical codewords 6 and 7: the lower index must win the tie
    half = $urandom;
    apply_config(IDX_W'(TIE_CW >> 1), {half, half});
    build_codeword_word(TIE_CW, SAMPLE_MAX, 0);
    send_word();
    drain_results();
  endtask

  task automatic test_random_traffic;
    int split;
    randomize_codebook();
    for (int w = 0; w < RANDOM_WORDS; w++) begin
      case (w % 4)
        0:       begin src_gap_max = GAP_MAX; sink_gap_max = GAP_MAX; end
        1:       begin src_gap_max = 0;       sink_gap_max = 0;       end
        2:       begin src_gap_max = 0;       sink_gap_max = GAP_MAX; end
        default: begin src_gap_max = GAP_MAX; sink_gap_max = 0;       end
      endcase
      case ($urandom_range(0, 9))
        0, 1: for (int i = 0; i < CHIPS; i++) word_chips[i] = CHIP_W'($urandom);
        2: for (int i = 0; i < CHIPS; i++)
             word_chips[i] = CHIP_W'($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN);
        default: build_codeword_word($urandom_range(0, scc_demap_pkg::MAX_CODEWORDS - 1),
                                     $urandom_range(1, SAMPLE_MAX),
                                     $urandom_range(0, 1500));
      endcase
      split = (w % 3 == 2) ? $urandom_range(1, CHIPS - 1) : CHIPS;
      for (int i = 0; i < CHIPS; i++) begin
        if (i == split) begin
          drain_results();
          randomize_codebook();
        end
        send_chip(word_chips[i]);
      end
      if (w == RANDOM_WORDS / 2) drain_results();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_soft_chip = '0;
    src_gap_max  = GAP_MAX;
    sink_gap_max = GAP_MAX;
    error_count     = 0;
    chips_sent      = 0;
    symbols_decoded = 0;
    config_writes   = 0;
    cycle_count     = 0;
    chip_pos        = 0;
    for (int p = 0; p < scc_demap_pkg::NUM_PAIRS; p++) codeword_regs[p] = '0;
    for (int c = 0; c < scc_demap_pkg::MAX_CODEWORDS; c++) corr_sums[c] = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_register_extremes();
    test_ignored_index();
    test_codeword_match();
    test_random_traffic();
    drain_results();

    $display("covered %0d chips, %0d decoded symbols, %0d register writes, %0d mismatches",
             chips_sent, symbols_decoded, config_writes, error_count);
    if (error_count == 0) begin
      $display("soft_codeword_correlation_demapper_top_tb: PASS");
    end else begin
      $display("soft_codeword_correlation_demapper_top_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
